@@ design/pdf_pkg.sv @@
// Shared constants, codes and types of the packet deframer.
package pdf_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned KIND_W = 3;
	localparam int unsigned INDEX_W = 5;
	localparam int unsigned MAXLEN_W = 6;
	localparam int unsigned COUNT_W = 6;
	localparam int unsigned PHASE_W = 3;
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned OUT_DATA_W = 32;

	localparam logic [MAXLEN_W-1:0] MAX_PAYLOAD = 6'd32;

	localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;
	localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 6'd32;

	localparam logic [0:0] REG_HEADER_VALUE = 1'b0;
	localparam logic [0:0] REG_MAX_LENGTH = 1'b1;

	localparam logic [PHASE_W-1:0] PH_HEADER = 3'd0;
	localparam logic [PHASE_W-1:0] PH_COMMAND = 3'd1;
	localparam logic [PHASE_W-1:0] PH_LENGTH = 3'd2;
	localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd3;
	localparam logic [PHASE_W-1:0] PH_CHECK = 3'd4;

	localparam logic [KIND_W-1:0] K_PAYLOAD = 3'd0;
	localparam logic [KIND_W-1:0] K_OK = 3'd1;
	localparam logic [KIND_W-1:0] K_HEADER_ERR = 3'd2;
	localparam logic [KIND_W-1:0] K_SUM_ERR = 3'd3;
	localparam logic [KIND_W-1:0] K_LEN_ERR = 3'd4;

	typedef struct packed {
		logic [BYTE_W-1:0]   header_value;
		logic [MAXLEN_W-1:0] max_length;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [BYTE_W-1:0]  cmd_code;
		logic [BYTE_W-1:0]  pay_length;
		logic [BYTE_W-1:0]  pay_byte;
		logic [INDEX_W-1:0] pay_index;
		logic               last;
	} result_t;

endpackage

@@ design/packet_deframer_sum8.sv @@
// Top level of the length-prefixed packet deframer with 8-bit sum checksum.
//
// Channel  Direction  Content
// s_axis   in         one received link byte per transaction
// m_axis   out        payload byte or packet status, tlast on the end of a packet
// apb      in/out     header_value at 0x0, max_length at 0x4
//
// Each byte is held in the input register, and its result in the result register.
// The frame step is only compares and one 8-bit add, so a byte is taken every cycle while the output is not stalled.
// While a held result waits for m_axis_tready, the input register keeps its byte and refills only if empty.
// Reset loads header_value 0xAA and max_length 32 and waits for a header byte.
module packet_deframer_sum8 (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [pdf_pkg::BYTE_W-1:0]         s_axis_tdata,  // [7:0] rx_byte
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [7:0] cmd_code, [15:8] pay_length, [23:16] pay_byte, [28:24] pay_index, [31:29] zero
	output logic [pdf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic [pdf_pkg::KIND_W-1:0]         m_axis_tuser,  // [2:0] kind
	output logic                               m_axis_tlast,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pdf_pkg::ADDR_W-1:0]         paddr,
	input  logic [pdf_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [pdf_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);

	pdf_pkg::cfg_t              cfg;
	logic                       valid_s1;
	logic [pdf_pkg::BYTE_W-1:0] byte_s1;
	logic                       out_free;
	logic                       step;
	logic                       res_valid;
	pdf_pkg::result_t           res;
	logic                       res_valid_q;
	pdf_pkg::result_t           res_q;

	pdf_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign out_free = !res_valid_q || m_axis_tready;
	assign step = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	pdf_frame_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (step),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata = {
		{(pdf_pkg::OUT_DATA_W - 3*pdf_pkg::BYTE_W - pdf_pkg::INDEX_W){1'b0}},
		res_q.pay_index, res_q.pay_byte, res_q.pay_length, res_q.cmd_code
	};
	assign m_axis_tuser = res_q.kind;
	assign m_axis_tlast = res_q.last;

endmodule

@@ design/pdf_cfg_regs.sv @@
// Configuration registers behind the APB-style port.
module pdf_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pdf_pkg::ADDR_W-1:0]       paddr,
	input  logic [pdf_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [pdf_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output pdf_pkg::cfg_t                    cfg
);

	pdf_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_value <= pdf_pkg::HEADER_RESET;
			cfg_q.max_length <= pdf_pkg::MAXLEN_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				pdf_pkg::REG_HEADER_VALUE: begin
					cfg_q.header_value <= pwdata[pdf_pkg::BYTE_W-1:0];
				end
				pdf_pkg::REG_MAX_LENGTH: begin
					cfg_q.max_length <= pwdata[pdf_pkg::MAXLEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			pdf_pkg::REG_HEADER_VALUE: begin
				prdata = {{(pdf_pkg::APB_DATA_W-pdf_pkg::BYTE_W){1'b0}}, cfg_q.header_value};
			end
			pdf_pkg::REG_MAX_LENGTH: begin
				prdata = {{(pdf_pkg::APB_DATA_W-pdf_pkg::MAXLEN_W){1'b0}}, cfg_q.max_length};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign cfg = cfg_q;

endmodule

@@ design/pdf_frame_fsm.sv @@
// Frame state and the per-byte step that turns one link byte into at most one result.
module pdf_frame_fsm (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pdf_pkg::cfg_t              cfg,
	input  logic                       step,
	input  logic [pdf_pkg::BYTE_W-1:0] rx_byte,
	output logic                       res_valid,
	output pdf_pkg::result_t           res
);

	logic [pdf_pkg::PHASE_W-1:0]  phase_q, phase_d;
	logic                         header_seen_q, header_seen_d;
	logic [pdf_pkg::BYTE_W-1:0]   command_q, command_d;
	logic [pdf_pkg::BYTE_W-1:0]   length_q, length_d;
	logic [pdf_pkg::BYTE_W-1:0]   sum_q, sum_d;
	logic [pdf_pkg::COUNT_W-1:0]  count_q, count_d;
	logic [pdf_pkg::BYTE_W-1:0]   sum_next;
	logic [pdf_pkg::COUNT_W-1:0]  count_next;
	logic [pdf_pkg::MAXLEN_W-1:0] limit;

	assign sum_next = sum_q + rx_byte;
	assign count_next = count_q + {{(pdf_pkg::COUNT_W-1){1'b0}}, 1'b1};
	assign limit = (cfg.max_length > pdf_pkg::MAX_PAYLOAD) ? pdf_pkg::MAX_PAYLOAD : cfg.max_length;

	always_comb begin
		phase_d = phase_q;
		header_seen_d = header_seen_q;
		command_d = command_q;
		length_d = length_q;
		sum_d = sum_q;
		count_d = count_q;
		res_valid = 1'b0;
		res.kind = pdf_pkg::K_PAYLOAD;
		res.cmd_code = command_q;
		res.pay_length = length_q;
		res.pay_byte = '0;
		res.pay_index = '0;
		res.last = 1'b0;
		case (phase_q)
			pdf_pkg::PH_COMMAND: begin
				command_d = rx_byte;
				sum_d = sum_next;
				phase_d = pdf_pkg::PH_LENGTH;
			end
			pdf_pkg::PH_LENGTH: begin
				length_d = rx_byte;
				sum_d = sum_next;
				count_d = '0;
				phase_d = pdf_pkg::PH_HEADER;
				res.pay_length = rx_byte;
				res.last = 1'b1;
				if (!header_seen_q) begin
					res_valid = 1'b1;
					res.kind = pdf_pkg::K_HEADER_ERR;
				end else if (rx_byte == '0) begin
					res_valid = 1'b1;
					res.kind = pdf_pkg::K_OK;
				end else if (rx_byte > {{(pdf_pkg::BYTE_W-pdf_pkg::MAXLEN_W){1'b0}}, limit}) begin
					res_valid = 1'b1;
					res.kind = pdf_pkg::K_LEN_ERR;
				end else begin
					phase_d = pdf_pkg::PH_PAYLOAD;
				end
			end
			pdf_pkg::PH_PAYLOAD: begin
				sum_d = sum_next;
				count_d = count_next;
				res_valid = 1'b1;
				res.kind = pdf_pkg::K_PAYLOAD;
				res.pay_byte = rx_byte;
				res.pay_index = count_q[pdf_pkg::INDEX_W-1:0];
				if ({{(pdf_pkg::BYTE_W-pdf_pkg::COUNT_W){1'b0}}, count_next} >= length_q) begin
					phase_d = pdf_pkg::PH_CHECK;
				end
			end
			pdf_pkg::PH_CHECK: begin
				phase_d = pdf_pkg::PH_HEADER;
				res_valid = 1'b1;
				res.kind = (rx_byte == sum_q) ? pdf_pkg::K_OK : pdf_pkg::K_SUM_ERR;
				res.last = 1'b1;
			end
			default: begin
				header_seen_d = (rx_byte == cfg.header_value);
				sum_d = rx_byte;
				command_d = '0;
				length_d = '0;
				count_d = '0;
				phase_d = pdf_pkg::PH_COMMAND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pdf_pkg::PH_HEADER;
			header_seen_q <= 1'b0;
			command_q <= '0;
			length_q <= '0;
			sum_q <= '0;
			count_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			header_seen_q <= header_seen_d;
			command_q <= command_d;
			length_q <= length_d;
			sum_q <= sum_d;
			count_q <= count_d;
		end
	end

endmodule

@@ tb/pdf_checker.sv @@
// Checker that predicts the deframer's results from observed transactions and compares them.
`timescale 1ns / 100ps

module pdf_checker
	import pdf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [BYTE_W-1:0]     s_axis_tdata,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic [KIND_W-1:0]     m_axis_tuser,
	input  logic                  m_axis_tlast,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic                  pready,
	output int                    mismatch_count,
	output int                    pending_count,
	output int                    bytes_seen,
	output int                    payload_seen,
	output int                    frames_good,
	output int                    frames_bad
);

	localparam logic [ADDR_W-1:0] HEADER_ADDR = {REG_HEADER_VALUE, 2'b00};
	localparam logic [ADDR_W-1:0] MAXLEN_ADDR = {REG_MAX_LENGTH, 2'b00};
	localparam int REPORT_LIMIT = 10;

	logic [BYTE_W-1:0]   header_cfg;
	logic [MAXLEN_W-1:0] maxlen_cfg;
	logic [PHASE_W-1:0]  frame_phase;
	logic                header_match;
	logic [BYTE_W-1:0]   cmd_held;
	logic [BYTE_W-1:0]   len_held;
	logic [BYTE_W-1:0]   frame_sum;
	logic [BYTE_W-1:0]   pay_count;
	result_t             due_results[$];

	function automatic result_t make_result(input logic [KIND_W-1:0] kind,
			input logic [BYTE_W-1:0] pay, input logic [INDEX_W-1:0] idx, input logic last);
		result_t r;
		r.kind = kind;
		r.cmd_code = cmd_held;
		r.pay_length = len_held;
		r.pay_byte = pay;
		r.pay_index = idx;
		r.last = last;
		return r;
	endfunction

	task automatic take_link_byte(input logic [BYTE_W-1:0] b);
		logic [MAXLEN_W-1:0] lim;
		logic [KIND_W-1:0]   end_kind;
		bytes_seen++;
		case (frame_phase)
			PH_COMMAND: begin
				cmd_held = b;
				frame_sum = frame_sum + b;
				frame_phase = PH_LENGTH;
			end
			PH_LENGTH: begin
				len_held = b;
				frame_sum = frame_sum + b;
				pay_count = '0;
				frame_phase = PH_HEADER;
				lim = (maxlen_cfg > MAX_PAYLOAD) ? MAX_PAYLOAD : maxlen_cfg;
				if (!header_match) begin
					due_results.push_back(make_result(K_HEADER_ERR, '0, '0, 1'b1));
					frames_bad++;
				end else if (b == '0) begin
					due_results.push_back(make_result(K_OK, '0, '0, 1'b1));
					frames_good++;
				end else if (b > {2'b00, lim}) begin
					due_results.push_back(make_result(K_LEN_ERR, '0, '0, 1'b1));
					frames_bad++;
				end else begin
					frame_phase = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				frame_sum = frame_sum + b;
				due_results.push_back(make_result(K_PAYLOAD, b, pay_count[INDEX_W-1:0], 1'b0));
				payload_seen++;
				pay_count = pay_count + 8'd1;
				if (pay_count >= len_held)
					frame_phase = PH_CHECK;
			end
			PH_CHECK: begin
				frame_phase = PH_HEADER;
				end_kind = (b == frame_sum) ? K_OK : K_SUM_ERR;
				due_results.push_back(make_result(end_kind, '0, '0, 1'b1));
				if (end_kind == K_OK)
					frames_good++;
				else
					frames_bad++;
			end
			default: begin
				header_match = (b == header_cfg);
				frame_sum = b;
				cmd_held = '0;
				len_held = '0;
				pay_count = '0;
				frame_phase = PH_COMMAND;
			end
		endcase
	endtask

	task automatic check_result();
		result_t act;
		result_t exp_r;
		act.kind = m_axis_tuser;
		act.cmd_code = m_axis_tdata[7:0];
		act.pay_length = m_axis_tdata[15:8];
		act.pay_byte = m_axis_tdata[23:16];
		act.pay_index = m_axis_tdata[28:24];
		act.last = m_axis_tlast;
		if (due_results.size() == 0) begin
			if (mismatch_count < REPORT_LIMIT)
				$display("%0t: unexpected result kind %0d tdata %08h last %0b",
					$realtime, m_axis_tuser, m_axis_tdata, m_axis_tlast);
			mismatch_count++;
		end else begin
			exp_r = due_results.pop_front();
			if (act !== exp_r || m_axis_tdata[31:29] !== 3'b000) begin
				if (mismatch_count < REPORT_LIMIT) begin
					$display("%0t: mismatch, expected kind %0d cmd %02h len %02h byte %02h idx %0d last %0b",
						$realtime, exp_r.kind, exp_r.cmd_code, exp_r.pay_length,
						exp_r.pay_byte, exp_r.pay_index, exp_r.last);
					$display("%0t: got kind %0d cmd %02h len %02h byte %02h idx %0d last %0b pad %0h",
						$realtime, act.kind, act.cmd_code, act.pay_length, act.pay_byte,
						act.pay_index, act.last, m_axis_tdata[31:29]);
				end
				mismatch_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_cfg = HEADER_RESET;
			maxlen_cfg = MAXLEN_RESET;
			frame_phase = PH_HEADER;
			header_match = 1'b0;
			cmd_held = '0;
			len_held = '0;
			frame_sum = '0;
			pay_count = '0;
			due_results.delete();
			mismatch_count = 0;
			pending_count = 0;
			bytes_seen = 0;
			payload_seen = 0;
			frames_good = 0;
			frames_bad = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == HEADER_ADDR)
					header_cfg = pwdata[BYTE_W-1:0];
				else if (paddr == MAXLEN_ADDR)
					maxlen_cfg = pwdata[MAXLEN_W-1:0];
			end
			if (s_axis_tvalid && s_axis_tready)
				take_link_byte(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			pending_count = due_results.size();
		end
	end

endmodule

@@ tb/tb_top.sv @@
// Top of the deframer testbench: clock, reset, traffic, register writes and the verdict.
`timescale 1ns / 100ps

module tb_top;
	import pdf_pkg::*;

	localparam int RX_HOLD = 120;
	localparam int PHASE_BYTES = 100;
	localparam int SETTINGS_RUN = 8;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [BYTE_W-1:0]     s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [KIND_W-1:0]     m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_W-1:0]     paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int mismatch_count;
	int pending_count;
	int bytes_seen;
	int payload_seen;
	int frames_good;
	int frames_bad;

	logic [BYTE_W-1:0]   cur_hdr;
	logic [MAXLEN_W-1:0] cur_max;
	int                  tx_gap_pct;
	int                  rx_stall_pct;
	int                  tx_sent;
	int                  rx_idle;
	int                  n_settings;
	bit                  stall_req;

	packet_deframer_sum8 i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	pdf_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser),
		.m_axis_tlast   (m_axis_tlast),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count),
		.bytes_seen     (bytes_seen),
		.payload_seen   (payload_seen),
		.frames_good    (frames_good),
		.frames_bad     (frames_bad)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("tb_top failed");
		$finish;
	end

	function automatic int pick_gap(input int pct);
		if ($urandom_range(99, 0) >= pct)
			return 0;
		if ($urandom_range(9, 0) == 0)
			return $urandom_range(30, 8);
		return $urandom_range(3, 1);
	endfunction

	// Receiver: random back-pressure, plus one long hold when requested.
	initial begin
		m_axis_tready = 1'b0;
		rx_idle = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (stall_req) begin
				m_axis_tready <= 1'b0;
				repeat (RX_HOLD) @(negedge clk);
				stall_req = 1'b0;
				m_axis_tready <= 1'b1;
			end else if (rx_idle > 0) begin
				m_axis_tready <= 1'b0;
				rx_idle--;
			end else begin
				rx_idle = pick_gap(rx_stall_pct);
				m_axis_tready <= (rx_idle == 0);
				if (rx_idle > 0)
					rx_idle--;
			end
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = pick_gap(tx_gap_pct);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		tx_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [APB_DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [BYTE_W-1:0] hdr, input logic [MAXLEN_W-1:0] mx);
		write_reg(REG_HEADER_VALUE, {24'($urandom), hdr});
		write_reg(REG_MAX_LENGTH, {26'($urandom), mx});
		cur_hdr = hdr;
		cur_max = mx;
		n_settings++;
	endtask

	// Payload and checksum follow only where the deframer will want them.
	task automatic send_packet(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] cmd,
			input logic [BYTE_W-1:0] len, input bit corrupt);
		logic [BYTE_W-1:0]   sum;
		logic [BYTE_W-1:0]   pb;
		logic [MAXLEN_W-1:0] lim;
		lim = (cur_max > MAX_PAYLOAD) ? MAX_PAYLOAD : cur_max;
		send_byte(hdr);
		send_byte(cmd);
		send_byte(len);
		sum = hdr + cmd + len;
		if (hdr == cur_hdr && len != 0 && len <= {2'b00, lim}) begin
			for (int i = 0; i < int'(len); i++) begin
				pb = 8'($urandom);
				sum = sum + pb;
				send_byte(pb);
			end
			send_byte(corrupt ? (sum ^ 8'($urandom_range(255, 1))) : sum);
		end
	endtask

	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_random(input int budget);
		int                  stop_at;
		int                  r;
		logic [BYTE_W-1:0]   len;
		logic [MAXLEN_W-1:0] lim;
		stop_at = tx_sent + budget;
		lim = (cur_max > MAX_PAYLOAD) ? MAX_PAYLOAD : cur_max;
		while (tx_sent < stop_at) begin
			r = $urandom_range(99, 0);
			if (r < 70) begin
				if (lim == 0)
					len = '0;
				else if ($urandom_range(9, 0) < 7)
					len = 8'($urandom_range((lim < 6'd6) ? int'(lim) : 6, 0));
				else
					len = 8'($urandom_range(int'(lim), 0));
				send_packet(cur_hdr, 8'($urandom), len, $urandom_range(4, 0) == 0);
			end else if (r < 80) begin
				send_packet(cur_hdr, 8'($urandom), 8'($urandom_range(255, int'(lim) + 1)), 1'b0);
			end else if (r < 90) begin
				send_packet(cur_hdr ^ 8'($urandom_range(255, 1)), 8'($urandom),
					8'($urandom), 1'b0);
			end else begin
				repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cur_hdr = HEADER_RESET;
		cur_max = MAXLEN_RESET;
		tx_gap_pct = 20;
		rx_stall_pct = 20;
		tx_sent = 0;
		n_settings = 1;
		stall_req = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_packet(8'hAA, 8'h00, 8'h01, 1'b0);
		send_packet(8'hAA, 8'hFF, 8'h00, 1'b0);
		send_packet(8'h55, 8'h12, 8'h07, 1'b0);
		send_packet(8'hAA, 8'h34, 8'hFF, 1'b0);
		send_packet(8'hAA, 8'h01, 8'h02, 1'b1);
		wait_drain();

		for (int k = 0; k < SETTINGS_RUN; k++) begin
			case (k)
				0: set_config(8'h00, 6'd1);
				1: set_config(8'hFF, 6'd63);
				2: set_config(8'h5A, 6'd0);
				3: set_config(8'($urandom), 6'd32);
				4: set_config(8'($urandom), 6'($urandom_range(32, 1)));
				5: set_config(8'($urandom), 6'($urandom_range(12, 2)));
				6: set_config(8'($urandom), 6'($urandom_range(63, 0)));
				default: set_config(HEADER_RESET, MAXLEN_RESET);
			endcase
			if (k % 3 == 0) begin
				tx_gap_pct = 0;
				rx_stall_pct = 0;
			end else begin
				tx_gap_pct = $urandom_range(40, 10);
				rx_stall_pct = $urandom_range(40, 10);
			end
			if (k == 1) begin
				// Hold the output back while a full-length packet streams in.
				tx_gap_pct = 0;
				stall_req = 1'b1;
				send_packet(cur_hdr, 8'h5C, 8'd32, 1'b0);
			end
			run_random(PHASE_BYTES);
			wait_drain();
		end

		repeat (8) @(negedge clk);
		$display("Covered %0d link bytes under %0d register settings.", bytes_seen, n_settings);
		$display("Saw %0d payload results, %0d good and %0d faulty packet endings.",
			payload_seen, frames_good, frames_bad);
		if (mismatch_count == 0 && pending_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
